@@ design/mos_pkg.sv @@
// ----------------------------------------------------------------------------
// mos_pkg: shared types and constants
// Sequencer states, item codes, opcodes and status flag masks.
// ----------------------------------------------------------------------------
package mos_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_OPC,
    S_OPR,
    S_LO,
    S_HI,
    S_WAIT
  } state_t;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_SETPC  = 2'd1,
    OP_STEP   = 2'd2,
    OP_UNUSED = 2'd3
  } item_op_t;

  localparam logic [7:0] OPC_BRK = 8'h00;
  localparam logic [7:0] OPC_ADC = 8'h69;
  localparam logic [7:0] OPC_STA = 8'h8D;
  localparam logic [7:0] OPC_LDA = 8'hA9;
  localparam logic [7:0] OPC_TAX = 8'hAA;
  localparam logic [7:0] OPC_INX = 8'hE8;

  localparam logic [7:0] FL_N = 8'h80;
  localparam logic [7:0] FL_V = 8'h40;
  localparam logic [7:0] FL_X = 8'h20;
  localparam logic [7:0] FL_B = 8'h10;
  localparam logic [7:0] FL_Z = 8'h02;
  localparam logic [7:0] FL_C = 8'h01;

  function automatic logic [7:0] set_zn(input logic [7:0] st, input logic [7:0] v);
    logic [7:0] r;
    r = st & ~(FL_Z | FL_N);
    if (v == 8'h00) begin
      r = r | FL_Z;
    end
    r = r | (v & FL_N);
    return r;
  endfunction

endpackage

@@ design/mos_ram.sv @@
// ----------------------------------------------------------------------------
// mos_ram: generic single-port RAM
// One read or write per cycle, read data registered.
// ----------------------------------------------------------------------------
module mos_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ design/mos6502_subset_core_unit.sv @@
// ----------------------------------------------------------------------------
// mos6502_subset_core_unit: small 6502-style core with its own byte memory
// Items load memory, set the program counter or run one instruction.
//
//   channel | handshake          | payload
//   --------+--------------------+----------------------------------------
//   input   | in_valid/in_ready  | op, addr, data
//   output  | out_valid/out_ready| acc_out, x_out, status_out, pc_out,
//           |                    | illegal_op
//
// Memory write, set PC and unused items finish in the idle step; an
// instruction adds the opcode step, then an operand step (ADC, LDA) or low
// and high address steps (STA, store in the high one): one memory port.
// One input buffer entry takes the next item while the sequencer works.
// The result register holds until transfer; a full register sends the
// sequencer to its wait step. Reset clears registers, sets FL_X, no RAM sweep.
// ----------------------------------------------------------------------------
module mos6502_subset_core_unit #(
  parameter int ADDR_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [15:0] addr,
  input  logic [7:0]  data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  acc_out,
  output logic [7:0]  x_out,
  output logic [7:0]  status_out,
  output logic [15:0] pc_out,
  output logic        illegal_op
);

  localparam int DEPTH = 1 << ADDR_BITS;

  mos_pkg::state_t state, state_next;

  logic        buf_valid;
  logic [1:0]  buf_op;
  logic [15:0] buf_addr;
  logic [7:0]  buf_data;
  logic        take;

  logic [7:0]  acc, acc_next;
  logic [7:0]  x, x_next;
  logic [7:0]  status, status_next;
  logic [15:0] pc, pc_next;
  logic [7:0]  opc, opc_next;
  logic [7:0]  lo, lo_next;
  logic        illegal_q, illegal_next;
  logic        ill_emit;
  logic        finish;
  logic        emit;
  logic        out_free;

  logic                 ram_we;
  logic [ADDR_BITS-1:0] ram_addr;
  logic [7:0]           ram_wdata;
  logic [7:0]           ram_rdata;

  logic [8:0]  sum;
  logic [7:0]  adc_r;
  logic [15:0] sta_addr;

  mos_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  assign out_free = !out_valid || out_ready;
  assign in_ready = !buf_valid || (state == mos_pkg::S_IDLE);

  assign sum      = {1'b0, acc} + {1'b0, ram_rdata} + {8'h00, status[0]};
  assign adc_r    = sum[7:0];
  assign sta_addr = {ram_rdata, lo};

  always_comb begin
    state_next   = state;
    acc_next     = acc;
    x_next       = x;
    status_next  = status;
    pc_next      = pc;
    opc_next     = opc;
    lo_next      = lo;
    illegal_next = illegal_q;
    ill_emit     = illegal_q;
    ram_we       = 1'b0;
    ram_addr     = pc[ADDR_BITS-1:0];
    ram_wdata    = acc;
    take         = 1'b0;
    finish       = 1'b0;
    emit         = 1'b0;
    case (state)
      mos_pkg::S_IDLE: begin
        illegal_next = 1'b0;
        ill_emit     = 1'b0;
        if (buf_valid) begin
          take = 1'b1;
          case (buf_op)
            mos_pkg::OP_WRITE: begin
              ram_we    = 1'b1;
              ram_addr  = buf_addr[ADDR_BITS-1:0];
              ram_wdata = buf_data;
              finish    = 1'b1;
            end
            mos_pkg::OP_SETPC: begin
              pc_next = buf_addr;
              finish  = 1'b1;
            end
            mos_pkg::OP_STEP: begin
              pc_next    = pc + 16'd1;
              state_next = mos_pkg::S_OPC;
            end
            default: begin
              finish = 1'b1;
            end
          endcase
        end
      end
      mos_pkg::S_OPC: begin
        opc_next = ram_rdata;
        case (ram_rdata)
          mos_pkg::OPC_ADC, mos_pkg::OPC_LDA: begin
            pc_next    = pc + 16'd1;
            state_next = mos_pkg::S_OPR;
          end
          mos_pkg::OPC_STA: begin
            pc_next    = pc + 16'd1;
            state_next = mos_pkg::S_LO;
          end
          mos_pkg::OPC_TAX: begin
            x_next      = acc;
            status_next = mos_pkg::set_zn(status, acc);
            finish      = 1'b1;
          end
          mos_pkg::OPC_INX: begin
            x_next      = x + 8'd1;
            status_next = mos_pkg::set_zn(status, x + 8'd1);
            finish      = 1'b1;
          end
          mos_pkg::OPC_BRK: begin
            status_next = status | mos_pkg::FL_B;
            finish      = 1'b1;
          end
          default: begin
            illegal_next = 1'b1;
            ill_emit     = 1'b1;
            finish       = 1'b1;
          end
        endcase
      end
      mos_pkg::S_OPR: begin
        if (opc == mos_pkg::OPC_ADC) begin
          acc_next    = adc_r;
          status_next = status & ~(mos_pkg::FL_C | mos_pkg::FL_V);
          if (sum[8]) begin
            status_next = status_next | mos_pkg::FL_C;
          end
          if ((~(acc ^ ram_rdata) & (acc ^ adc_r) & 8'h80) != 8'h00) begin
            status_next = status_next | mos_pkg::FL_V;
          end
          status_next = mos_pkg::set_zn(status_next, adc_r);
        end else begin
          acc_next    = ram_rdata;
          status_next = mos_pkg::set_zn(status, ram_rdata);
        end
        finish = 1'b1;
      end
      mos_pkg::S_LO: begin
        lo_next    = ram_rdata;
        pc_next    = pc + 16'd1;
        state_next = mos_pkg::S_HI;
      end
      mos_pkg::S_HI: begin
        ram_we   = 1'b1;
        ram_addr = sta_addr[ADDR_BITS-1:0];
        finish   = 1'b1;
      end
      mos_pkg::S_WAIT: begin
        finish = 1'b1;
      end
      default: begin
        state_next = mos_pkg::S_IDLE;
      end
    endcase
    if (finish) begin
      if (out_free) begin
        emit       = 1'b1;
        state_next = mos_pkg::S_IDLE;
      end else begin
        state_next = mos_pkg::S_WAIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mos_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
      out_valid <= 1'b0;
      acc       <= 8'h00;
      x         <= 8'h00;
      status    <= mos_pkg::FL_X;
      pc        <= 16'h0000;
      illegal_q <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        buf_valid <= 1'b1;
      end else if (take) begin
        buf_valid <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      acc       <= acc_next;
      x         <= x_next;
      status    <= status_next;
      pc        <= pc_next;
      illegal_q <= illegal_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      buf_op   <= op;
      buf_addr <= addr;
      buf_data <= data;
    end
    opc <= opc_next;
    lo  <= lo_next;
    if (emit) begin
      acc_out    <= acc_next;
      x_out      <= x_next;
      status_out <= status_next;
      pc_out     <= pc_next;
      illegal_op <= ill_emit;
    end
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    emit |-> (!out_valid || out_ready))
    else $error("result overwrites a pending result");

  a_write_state: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == mos_pkg::S_IDLE || state == mos_pkg::S_HI))
    else $error("memory write outside write steps");

  a_opc_from_idle: assert property (@(posedge clk) disable iff (rst)
    (state == mos_pkg::S_OPC) |-> ($past(state) == mos_pkg::S_IDLE))
    else $error("opcode step not entered from idle");

  a_pc_fetch: assert property (@(posedge clk) disable iff (rst)
    (state == mos_pkg::S_OPC) |-> (pc == ($past(pc) + 16'd1)))
    else $error("program counter not advanced by opcode fetch");

endmodule

@@ verif/mos_core_checker.sv @@
// ----------------------------------------------------------------------------
// mos_core_checker: result checker for mos6502_subset_core_unit
// Follows every input transfer with its own model of the core (registers,
// flags and byte memory), queues the register view expected after each item
// and compares every output transfer against the oldest queued view.
// ----------------------------------------------------------------------------
module mos_core_checker #(
  parameter int ADDR_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  op,
  input  logic [15:0] addr,
  input  logic [7:0]  data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  acc_out,
  input  logic [7:0]  x_out,
  input  logic [7:0]  status_out,
  input  logic [15:0] pc_out,
  input  logic        illegal_op,
  output int          errors,
  output int          pending
);

  localparam logic [15:0] AMASK = 16'((32'd1 << ADDR_BITS) - 1);

  typedef struct packed {
    logic [7:0]  acc;
    logic [7:0]  x;
    logic [7:0]  status;
    logic [15:0] pc;
    logic        illegal;
  } core_view_t;

  logic [7:0]  ram [0:65535];
  logic [7:0]  a_reg;
  logic [7:0]  x_reg;
  logic [7:0]  p_reg;
  logic [15:0] pc_reg;
  core_view_t  expected_views[$];

  function automatic logic [7:0] zn_flags(input logic [7:0] st, input logic [7:0] v);
    return (st & ~(mos_pkg::FL_Z | mos_pkg::FL_N)) | (v & mos_pkg::FL_N) |
           ((v == 8'h00) ? mos_pkg::FL_Z : 8'h00);
  endfunction

  function automatic logic [7:0] fetch_byte();
    logic [7:0] b;
    b = ram[pc_reg & AMASK];
    pc_reg = pc_reg + 16'd1;
    return b;
  endfunction

  task automatic advance_core(input logic [1:0] o, input logic [15:0] a,
                              input logic [7:0] d);
    logic [7:0] opc;
    logic [7:0] m;
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] r;
    logic [8:0] sum;
    logic       bad;
    bad = 1'b0;
    case (mos_pkg::item_op_t'(o))
      mos_pkg::OP_WRITE: begin
        ram[a & AMASK] = d;
      end
      mos_pkg::OP_SETPC: begin
        pc_reg = a;
      end
      mos_pkg::OP_STEP: begin
        opc = fetch_byte();
        case (opc)
          mos_pkg::OPC_ADC: begin
            m = fetch_byte();
            sum = {1'b0, a_reg} + {1'b0, m} + 9'((p_reg & mos_pkg::FL_C) != 8'h00);
            r = sum[7:0];
            p_reg = p_reg & ~(mos_pkg::FL_C | mos_pkg::FL_V);
            if (sum[8]) begin
              p_reg = p_reg | mos_pkg::FL_C;
            end
            if ((~(a_reg ^ m) & (a_reg ^ r) & 8'h80) != 8'h00) begin
              p_reg = p_reg | mos_pkg::FL_V;
            end
            a_reg = r;
            p_reg = zn_flags(p_reg, r);
          end
          mos_pkg::OPC_STA: begin
            lo = fetch_byte();
            hi = fetch_byte();
            ram[{hi, lo} & AMASK] = a_reg;
          end
          mos_pkg::OPC_LDA: begin
            a_reg = fetch_byte();
            p_reg = zn_flags(p_reg, a_reg);
          end
          mos_pkg::OPC_TAX: begin
            x_reg = a_reg;
            p_reg = zn_flags(p_reg, x_reg);
          end
          mos_pkg::OPC_INX: begin
            x_reg = x_reg + 8'd1;
            p_reg = zn_flags(p_reg, x_reg);
          end
          mos_pkg::OPC_BRK: begin
            p_reg = p_reg | mos_pkg::FL_B;
          end
          default: begin
            bad = 1'b1;
          end
        endcase
      end
      default: begin
      end
    endcase
    expected_views.push_back('{a_reg, x_reg, p_reg, pc_reg, bad});
  endtask

  always @(posedge clk) begin
    core_view_t want;
    if (rst) begin
      a_reg = 8'h00;
      x_reg = 8'h00;
      p_reg = mos_pkg::FL_X;
      pc_reg = 16'h0000;
      expected_views.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_views.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("[%0t] transfer with nothing pending: acc=%h x=%h st=%h pc=%h ill=%b",
                     $realtime, acc_out, x_out, status_out, pc_out, illegal_op);
          end
        end else begin
          want = expected_views.pop_front();
          if (acc_out !== want.acc || x_out !== want.x || status_out !== want.status ||
              pc_out !== want.pc || illegal_op !== want.illegal) begin
            errors++;
            if (errors <= 10) begin
              $display("[%0t] mismatch: exp acc=%h x=%h st=%h pc=%h ill=%b",
                       $realtime, want.acc, want.x, want.status, want.pc, want.illegal);
              $display("           got acc=%h x=%h st=%h pc=%h ill=%b",
                       acc_out, x_out, status_out, pc_out, illegal_op);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        advance_core(op, addr, data);
      end
    end
    pending = expected_views.size();
  end

endmodule

@@ verif/tb_mos6502_subset_core_unit.sv @@
// ----------------------------------------------------------------------------
// tb_mos6502_subset_core_unit: testbench for the 6502-style subset core
// Loads short programs of random content, points the program counter at them
// and steps through them, mixed with loose writes, jumps and unused items.
// A byte map of the memory keeps every fetch on bytes that were written.
// Both channels stall at random in two phases; the checker judges results.
// ----------------------------------------------------------------------------
module tb_mos6502_subset_core_unit;

  localparam int          ADDR_BITS   = 16;
  localparam int          ITEM_TARGET = 1800;
  localparam int          CYCLE_LIMIT = 400000;
  localparam logic [15:0] AMASK       = 16'((32'd1 << ADDR_BITS) - 1);

  typedef enum logic [1:0] {
    B_EMPTY,
    B_KNOWN,
    B_STORED
  } byte_state_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  op;
  logic [15:0] addr;
  logic [7:0]  data;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  acc_out;
  logic [7:0]  x_out;
  logic [7:0]  status_out;
  logic [15:0] pc_out;
  logic        illegal_op;
  int          errors;
  int          pending;

  byte_state_t byte_st [0:65535];
  logic [7:0]  byte_val [0:65535];
  logic [15:0] pc_track;
  bit          pc_valid = 1'b1;
  int          items_sent = 0;
  int          send_idle_pct = 7;
  int          recv_idle_pct = 84;
  int          hold_len = 0;
  int          cycles;

  mos6502_subset_core_unit #(.ADDR_BITS(ADDR_BITS)) uut (.*);

  mos_core_checker #(.ADDR_BITS(ADDR_BITS)) chk (.*);

  initial begin
    clk = 1'b0;
    forever begin
      #5 clk = ~clk;
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_len > 0) begin
        out_ready <= 1'b0;
        hold_len--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic logic [15:0] slot(input logic [15:0] a);
    return a & AMASK;
  endfunction

  function automatic int insn_len(input logic [7:0] opc);
    case (opc)
      mos_pkg::OPC_STA: return 3;
      mos_pkg::OPC_ADC, mos_pkg::OPC_LDA: return 2;
      default: return 1;
    endcase
  endfunction

  function automatic bit step_safe();
    int n;
    if (!pc_valid || byte_st[slot(pc_track)] != B_KNOWN) begin
      return 1'b0;
    end
    n = insn_len(byte_val[slot(pc_track)]);
    for (int i = 1; i < n; i++) begin
      if (byte_st[slot(16'(pc_track + i))] != B_KNOWN) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic logic [7:0] operand_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'h7F;
      2: return 8'h80;
      3: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // offer one item; returns right after its transfer edge
  task automatic send_item(input mos_pkg::item_op_t o, input logic [15:0] a,
                           input logic [7:0] d);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    addr <= a;
    data <= d;
    do begin
      @(posedge clk);
    end while (!in_ready);
    if (o != mos_pkg::OP_UNUSED) begin
      items_sent++;
    end
  endtask

  task automatic put_byte(input logic [15:0] a, input logic [7:0] d);
    byte_st[slot(a)] = B_KNOWN;
    byte_val[slot(a)] = d;
    send_item(mos_pkg::OP_WRITE, a, d);
  endtask

  task automatic jump(input logic [15:0] a);
    pc_track = a;
    pc_valid = 1'b1;
    send_item(mos_pkg::OP_SETPC, a, 8'($urandom));
  endtask

  task automatic step();
    logic [15:0] p;
    logic [7:0]  opc;
    p = pc_track;
    if (step_safe()) begin
      opc = byte_val[slot(p)];
      if (opc == mos_pkg::OPC_STA) begin
        byte_st[slot({byte_val[slot(16'(p + 2))], byte_val[slot(16'(p + 1))]})] = B_STORED;
      end
      pc_track = 16'(p + insn_len(opc));
    end else begin
      pc_valid = 1'b0;
    end
    send_item(mos_pkg::OP_STEP, 16'($urandom), 8'($urandom));
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic run_program();
    logic [7:0]  prog [0:23];
    logic [15:0] base;
    logic [15:0] entry;
    int          len;
    int          n_insn;
    int          skip;
    int          runs;
    len = 0;
    skip = -1;
    n_insn = $urandom_range(1, 8);
    base = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(16'hFFF0, 16'hFFFF))
                                       : 16'($urandom);
    entry = base;
    for (int i = 0; i < n_insn; i++) begin
      case ($urandom_range(0, 13))
        0, 1, 2: begin
          prog[len] = mos_pkg::OPC_ADC;
          prog[len + 1] = operand_byte();
          len += 2;
        end
        3, 4: begin
          prog[len] = mos_pkg::OPC_LDA;
          prog[len + 1] = operand_byte();
          len += 2;
        end
        5, 6: begin
          prog[len] = mos_pkg::OPC_STA;
          prog[len + 1] = 8'($urandom);
          prog[len + 2] = 8'($urandom);
          len += 3;
        end
        7, 8: begin
          prog[len] = mos_pkg::OPC_TAX;
          len += 1;
        end
        9, 10: begin
          prog[len] = mos_pkg::OPC_INX;
          len += 1;
        end
        11: begin
          prog[len] = mos_pkg::OPC_BRK;
          len += 1;
        end
        default: begin
          prog[len] = 8'($urandom);
          len += 1;
        end
      endcase
    end
    case ($urandom_range(0, 9))
      0: skip = $urandom_range(0, len - 1);
      1: entry = 16'(base + 1);
      default: begin
      end
    endcase
    for (int i = 0; i < len; i++) begin
      if (i != skip) begin
        put_byte(16'(base + i), prog[i]);
      end
    end
    jump(entry);
    runs = n_insn + $urandom_range(0, 2);
    for (int i = 0; i < runs; i++) begin
      if (!step_safe()) begin
        break;
      end
      step();
    end
  endtask

  task automatic noise_item();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: put_byte(16'($urandom), 8'($urandom));
      4, 5: jump(16'($urandom));
      6, 7, 8: begin
        if (step_safe()) begin
          step();
        end else begin
          put_byte(16'($urandom), 8'($urandom));
        end
      end
      default: send_item(mos_pkg::OP_UNUSED, 16'($urandom), 8'($urandom));
    endcase
  endtask

  task automatic run_random(input int upto);
    while (items_sent < upto) begin
      if ($urandom_range(99) < 80) begin
        run_program();
      end else begin
        noise_item();
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    op = mos_pkg::OP_WRITE;
    addr = 16'h0000;
    data = 8'h00;
    for (int i = 0; i < 65536; i++) begin
      byte_st[i] = B_EMPTY;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // program across the top of memory: overflow, carry out, wrap of PC,
    // store to the last address, break and an unsupported opcode
    put_byte(16'hFFFC, mos_pkg::OPC_LDA);
    put_byte(16'hFFFD, 8'h7F);
    put_byte(16'hFFFE, mos_pkg::OPC_ADC);
    put_byte(16'hFFFF, 8'h01);
    put_byte(16'h0000, mos_pkg::OPC_ADC);
    put_byte(16'h0001, 8'h80);
    put_byte(16'h0002, mos_pkg::OPC_TAX);
    put_byte(16'h0003, mos_pkg::OPC_INX);
    put_byte(16'h0004, mos_pkg::OPC_STA);
    put_byte(16'h0005, 8'hFF);
    put_byte(16'h0006, 8'hFF);
    put_byte(16'h0007, mos_pkg::OPC_BRK);
    put_byte(16'h0008, 8'hFF);
    send_item(mos_pkg::OP_UNUSED, 16'hFFFF, 8'hFF);
    jump(16'hFFFC);
    repeat (8) step();

    run_random(ITEM_TARGET / 3);
    drain();
    send_idle_pct = 84;
    recv_idle_pct = 7;
    run_random(2 * ITEM_TARGET / 3);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_len = 400;
    run_random(ITEM_TARGET);
    drain();
    repeat (20) @(negedge clk);

    if (errors == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
